// File: hdl/best_fit_range_allocator_defines.svh
// assertion macros shared by the allocator rtl
`ifndef BEST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BFRA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("bfra check failed");
`define BFRA_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("bfra check failed");
`else
`define BFRA_ASSERT(lbl, clk, rst_n, prop)
`define BFRA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: hdl/bfra_pkg.sv
// types, codes and widths shared by the allocator modules
package bfra_pkg;
	localparam int HEAP_MAX_DEF = 1024;
	localparam int RANGES_DEF = 64;
	localparam int STALE_DEF = 64;

	localparam int CMD_W = 2;
	localparam int OFF_W = 10;
	localparam int CNT_W = 11;
	localparam int FRAME_W = 64;
	localparam int AGE_W = 16;
	localparam int STAT_W = 3;
	localparam int REL_W = 7;
	localparam int SUM_W = CNT_W + 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_NONE = 2'd3
	} bfra_cmd_e;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 3'd0,
		ST_NO_SPACE = 3'd1,
		ST_BAD_COUNT = 3'd2,
		ST_QUEUE_FULL = 3'd3,
		ST_TABLE_FULL = 3'd4
	} bfra_status_e;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [CNT_W-1:0] size;
		logic [AGE_W-1:0] age;
	} bfra_range_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [CNT_W-1:0] size;
		logic [FRAME_W-1:0] frame;
	} bfra_stale_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic scan_start;
		logic alloc_commit;
		logic push_commit;
		logic merge_commit;
		logic set_status;
		bfra_status_e status_code;
		logic out_load;
	} bfra_ctl_t;

	// datapath to controller
	typedef struct packed {
		bfra_cmd_e cmd;
		logic cnt_zero;
		logic cnt_gt_free;
		logic free_bad;
		logic queue_full;
		logic queue_empty;
		logic head_due;
		logic scan_done;
		logic best_found;
		logic merge_fail;
		logic out_free;
	} bfra_sts_t;
endpackage

// File: hdl/best_fit_range_allocator.sv
// best-fit free range allocator with frame-tagged deferred frees
// scan passes per accepted word (a pass reads all N = MAX_FREE_RANGES table entries):
//   allocate takes two passes (one if rejected at the check), free, invalid and unknown words one,
//   release one pass per returned range plus a final one
// one item at a time: a new word is taken only while idle, never during a range table scan
// reset: arst_n clears to one free range [0, HEAP_MAX), empty stale queue
module best_fit_range_allocator #(
	parameter int HEAP_MAX = bfra_pkg::HEAP_MAX_DEF,
	parameter int MAX_FREE_RANGES = bfra_pkg::RANGES_DEF,
	parameter int STALE_DEPTH = bfra_pkg::STALE_DEF
) (
	input logic clk,
	input logic arst_n,
	// input word
	input logic s_tvalid,
	output logic s_tready,
	input logic [87:0] s_tdata, // command, block_offset, block_count, frame_number
	// result word
	output logic m_tvalid,
	input logic m_tready,
	output logic [47:0] m_tdata, // status, alloc_offset, free_slots, largest_free, released_count
	// heap_size register
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bfra_pkg::CNT_W-1:0] cfg_data
);
	import bfra_pkg::*;

	bfra_ctl_t ctl;
	bfra_sts_t sts;
	logic idle;
	logic [STAT_W-1:0] o_status;
	logic [OFF_W-1:0] o_aoff;
	logic [CNT_W-1:0] o_free, o_largest;
	logic [REL_W-1:0] o_rel;

	// config writes only land between items; a config write goes first if both arrive
	assign cfg_ready = idle;
	assign s_tready = idle && !cfg_valid;

	bfra_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_accept(s_tvalid && s_tready),
		.sts(sts),
		.ctl(ctl),
		.idle(idle)
	);

	bfra_dp #(
		.HEAP_MAX(HEAP_MAX),
		.MAX_FREE_RANGES(MAX_FREE_RANGES),
		.STALE_DEPTH(STALE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_cmd(s_tdata[1:0]),
		.in_off(s_tdata[11:2]),
		.in_cnt(s_tdata[22:12]),
		.in_frame(s_tdata[86:23]),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.ctl(ctl),
		.sts(sts),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_status(o_status),
		.out_alloc_offset(o_aoff),
		.out_free_slots(o_free),
		.out_largest_free(o_largest),
		.out_released_count(o_rel)
	);

	// pack result fields from the low bit up, pad to whole bytes
	assign m_tdata = {6'd0, o_rel, o_largest, o_free, o_aoff, o_status};
endmodule

// File: hdl/bfra_ctrl.sv
// command sequencer for the allocator
`include "best_fit_range_allocator_defines.svh"
module bfra_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_accept,
	input bfra_pkg::bfra_sts_t sts,
	output bfra_pkg::bfra_ctl_t ctl,
	output logic idle
);
	import bfra_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_FIT = 8'b0000_0100,
		S_REL_TEST = 8'b0000_1000,
		S_MSCAN = 8'b0001_0000,
		S_REL_WAIT = 8'b0010_0000,
		S_LSCAN = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_nxt;

	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		ctl = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					ctl.load_item = 1'b1;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				case (sts.cmd)
					CMD_ALLOC: begin
						ctl.scan_start = 1'b1;
						if (sts.cnt_zero) begin
							ctl.set_status = 1'b1;
							ctl.status_code = ST_BAD_COUNT;
							state_nxt = S_LSCAN;
						end else if (sts.cnt_gt_free) begin
							ctl.set_status = 1'b1;
							ctl.status_code = ST_NO_SPACE;
							state_nxt = S_LSCAN;
						end else begin
							state_nxt = S_FIT;
						end
					end
					CMD_FREE: begin
						ctl.scan_start = 1'b1;
						state_nxt = S_LSCAN;
						if (sts.cnt_zero || sts.free_bad) begin
							ctl.set_status = 1'b1;
							ctl.status_code = ST_BAD_COUNT;
						end else if (sts.queue_full) begin
							ctl.set_status = 1'b1;
							ctl.status_code = ST_QUEUE_FULL;
						end else begin
							ctl.push_commit = 1'b1;
						end
					end
					CMD_RELEASE: state_nxt = S_REL_TEST;
					default: begin
						ctl.scan_start = 1'b1;
						state_nxt = S_LSCAN;
					end
				endcase
			end
			S_FIT: begin
				if (sts.scan_done) begin
					if (sts.best_found) begin
						ctl.alloc_commit = 1'b1;
					end else begin
						ctl.set_status = 1'b1;
						ctl.status_code = ST_NO_SPACE;
					end
					ctl.scan_start = 1'b1;
					state_nxt = S_LSCAN;
				end
			end
			S_REL_TEST: begin
				ctl.scan_start = 1'b1;
				if (!sts.queue_empty && sts.head_due) begin
					state_nxt = S_MSCAN;
				end else begin
					state_nxt = S_LSCAN;
				end
			end
			S_MSCAN: begin
				if (sts.scan_done) begin
					if (sts.merge_fail) begin
						ctl.set_status = 1'b1;
						ctl.status_code = ST_TABLE_FULL;
						ctl.scan_start = 1'b1;
						state_nxt = S_LSCAN;
					end else begin
						ctl.merge_commit = 1'b1;
						state_nxt = S_REL_WAIT;
					end
				end
			end
			S_REL_WAIT: state_nxt = S_REL_TEST;
			S_LSCAN: begin
				if (sts.scan_done) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	`BFRA_ASSERT(a_load_needs_room, clk, arst_n, ctl.out_load |-> sts.out_free)
	`BFRA_ASSERT(a_commit_after_scan, clk, arst_n, (ctl.alloc_commit || ctl.merge_commit) |-> sts.scan_done)
	`BFRA_ASSERT(a_item_then_check, clk, arst_n, in_accept |=> !idle)
endmodule

// File: hdl/bfra_dp.sv
// range table, stale queue, scan unit and result register
`include "best_fit_range_allocator_defines.svh"
module bfra_dp #(
	parameter int HEAP_MAX = bfra_pkg::HEAP_MAX_DEF,
	parameter int MAX_FREE_RANGES = bfra_pkg::RANGES_DEF,
	parameter int STALE_DEPTH = bfra_pkg::STALE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [bfra_pkg::CMD_W-1:0] in_cmd,
	input logic [bfra_pkg::OFF_W-1:0] in_off,
	input logic [bfra_pkg::CNT_W-1:0] in_cnt,
	input logic [bfra_pkg::FRAME_W-1:0] in_frame,
	input logic cfg_we,
	input logic [bfra_pkg::CNT_W-1:0] cfg_data,
	input bfra_pkg::bfra_ctl_t ctl,
	output bfra_pkg::bfra_sts_t sts,
	input logic out_ready,
	output logic out_valid,
	output logic [bfra_pkg::STAT_W-1:0] out_status,
	output logic [bfra_pkg::OFF_W-1:0] out_alloc_offset,
	output logic [bfra_pkg::CNT_W-1:0] out_free_slots,
	output logic [bfra_pkg::CNT_W-1:0] out_largest_free,
	output logic [bfra_pkg::REL_W-1:0] out_released_count
);
	import bfra_pkg::*;

	localparam int RI_W = (MAX_FREE_RANGES > 1) ? $clog2(MAX_FREE_RANGES) : 1;
	localparam int SI_W = (STALE_DEPTH > 1) ? $clog2(STALE_DEPTH) : 1;
	localparam int FILL_W = $clog2(STALE_DEPTH + 1);
	localparam int TS_W = SI_W + 2;

	// item and config registers
	logic [CNT_W-1:0] heap_q, free_q;
	bfra_cmd_e cmd_q;
	logic [OFF_W-1:0] off_q, aoff_q;
	logic [CNT_W-1:0] cnt_q;
	logic [FRAME_W-1:0] frame_q;
	logic [AGE_W-1:0] stamp_q;
	logic [MAX_FREE_RANGES-1:0] valid_q, valid_nxt;
	logic ovr0_q;
	logic [SI_W-1:0] head_q;
	logic [FILL_W-1:0] fill_q;
	logic [REL_W-1:0] rel_q;
	bfra_status_e status_q;

	// memories
	bfra_range_t range_mem [MAX_FREE_RANGES];
	bfra_stale_t stale_mem [STALE_DEPTH];
	bfra_stale_t stale_rd_q;

	// scan
	logic [RI_W-1:0] ptr_q, idx_s1;
	logic scan_on_q, act_s1, vld_s1, done_q;
	bfra_range_t ent_s1, ent;
	logic [AGE_W-1:0] age_gap;

	logic inv_found_q, best_found_q, pf_q, nf_q;
	logic [RI_W-1:0] inv_idx_q, best_idx_q, prev_idx_q, next_idx_q;
	logic [OFF_W-1:0] best_start_q, prev_start_q, next_start_q;
	logic [CNT_W-1:0] best_size_q, prev_size_q, next_size_q, max_q;
	logic [AGE_W-1:0] best_dist_q;

	// commit logic
	logic [CNT_W-1:0] rest, cfg_heap;
	logic [RI_W-1:0] alloc_idx, m_idx;
	logic prev_adj, next_adj, m_ok;
	logic [OFF_W-1:0] m_off;
	logic [SUM_W-1:0] m_sz, m_sz2, sat_sum;
	logic wr_en;
	logic [RI_W-1:0] wr_idx;
	bfra_range_t wr_data;
	logic [TS_W-1:0] tail_sum;
	logic [SI_W-1:0] tail;
	logic out_valid_q;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_heap = CNT_W'(1);
		end else if (int'(cfg_data) > HEAP_MAX) begin
			cfg_heap = CNT_W'(HEAP_MAX);
		end else begin
			cfg_heap = cfg_data;
		end
	end

	// entry 0 reads as the whole heap until first written
	always_comb begin
		ent = ent_s1;
		if (ovr0_q && idx_s1 == '0) begin
			ent.start = '0;
			ent.size = heap_q;
			ent.age = '0;
		end
	end
	assign age_gap = stamp_q - ent.age;

	assign rest = best_size_q - cnt_q;
	assign alloc_idx = (inv_found_q && inv_idx_q < best_idx_q) ? inv_idx_q : best_idx_q;

	always_comb begin
		prev_adj = pf_q && (SUM_W'(prev_start_q) + SUM_W'(prev_size_q) == SUM_W'(stale_rd_q.off));
		m_off = prev_adj ? prev_start_q : stale_rd_q.off;
		m_sz = prev_adj ? SUM_W'(prev_size_q) + SUM_W'(stale_rd_q.size) : SUM_W'(stale_rd_q.size);
		next_adj = nf_q && (SUM_W'(m_off) + m_sz == SUM_W'(next_start_q));
		m_sz2 = next_adj ? m_sz + SUM_W'(next_size_q) : m_sz;
		m_ok = inv_found_q;
		m_idx = inv_idx_q;
		if (prev_adj && (!m_ok || prev_idx_q < m_idx)) begin
			m_ok = 1'b1;
			m_idx = prev_idx_q;
		end
		if (next_adj && (!m_ok || next_idx_q < m_idx)) begin
			m_ok = 1'b1;
			m_idx = next_idx_q;
		end
		sat_sum = SUM_W'(free_q) + SUM_W'(stale_rd_q.size);
	end

	always_comb begin
		wr_en = 1'b0;
		wr_idx = alloc_idx;
		wr_data.start = best_start_q + OFF_W'(cnt_q);
		wr_data.size = rest;
		wr_data.age = stamp_q;
		if (ctl.alloc_commit) begin
			wr_en = (rest != '0);
		end else if (ctl.merge_commit && m_ok) begin
			wr_en = 1'b1;
			wr_idx = m_idx;
			wr_data.start = m_off;
			wr_data.size = CNT_W'(m_sz2);
		end
	end

	// valid bits after a commit: clear the taken or merged entries, then set the written one
	always_comb begin
		valid_nxt = valid_q;
		if (ctl.alloc_commit) begin
			valid_nxt[best_idx_q] = 1'b0;
			if (rest != '0) begin
				valid_nxt[alloc_idx] = 1'b1;
			end
		end else if (ctl.merge_commit && m_ok) begin
			if (prev_adj) begin
				valid_nxt[prev_idx_q] = 1'b0;
			end
			if (next_adj) begin
				valid_nxt[next_idx_q] = 1'b0;
			end
			valid_nxt[m_idx] = 1'b1;
		end
	end

	assign tail_sum = TS_W'(head_q) + TS_W'(fill_q);
	assign tail = (tail_sum >= TS_W'(STALE_DEPTH)) ? SI_W'(tail_sum - TS_W'(STALE_DEPTH))
		: SI_W'(tail_sum);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			range_mem[wr_idx] <= wr_data;
		end
		ent_s1 <= range_mem[ptr_q];
		if (ctl.push_commit) begin
			stale_mem[tail] <= '{off: off_q, size: cnt_q, frame: frame_q};
		end
		stale_rd_q <= stale_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q <= bfra_cmd_e'(in_cmd);
			off_q <= in_off;
			cnt_q <= in_cnt;
			frame_q <= in_frame;
		end
	end

	// table and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= CNT_W'(HEAP_MAX);
			free_q <= CNT_W'(HEAP_MAX);
			valid_q <= MAX_FREE_RANGES'(1);
			ovr0_q <= 1'b1;
			stamp_q <= AGE_W'(1);
			head_q <= '0;
			fill_q <= '0;
			rel_q <= '0;
			status_q <= ST_OK;
			aoff_q <= '0;
		end else if (cfg_we) begin
			heap_q <= cfg_heap;
			free_q <= cfg_heap;
			valid_q <= MAX_FREE_RANGES'(1);
			ovr0_q <= 1'b1;
			stamp_q <= AGE_W'(1);
			head_q <= '0;
			fill_q <= '0;
		end else begin
			valid_q <= valid_nxt;
			if (ctl.load_item) begin
				rel_q <= '0;
				status_q <= ST_OK;
				aoff_q <= '0;
			end
			if (ctl.set_status) begin
				status_q <= ctl.status_code;
			end
			if (wr_en) begin
				stamp_q <= stamp_q + AGE_W'(1);
				if (wr_idx == '0) begin
					ovr0_q <= 1'b0;
				end
			end
			if (ctl.alloc_commit) begin
				free_q <= free_q - cnt_q;
				aoff_q <= best_start_q;
			end
			if (ctl.push_commit) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (ctl.merge_commit && m_ok) begin
				free_q <= (sat_sum > SUM_W'(heap_q)) ? heap_q : CNT_W'(sat_sum);
				head_q <= (head_q == SI_W'(STALE_DEPTH - 1)) ? '0 : head_q + SI_W'(1);
				fill_q <= fill_q - FILL_W'(1);
				rel_q <= rel_q + REL_W'(1);
			end
		end
	end

	// scan: read one entry a cycle, fold it in on the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			scan_on_q <= 1'b0;
			act_s1 <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.scan_start) begin
			ptr_q <= '0;
			scan_on_q <= 1'b1;
			act_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			act_s1 <= scan_on_q;
			if (scan_on_q) begin
				ptr_q <= ptr_q + RI_W'(1);
				if (ptr_q == RI_W'(MAX_FREE_RANGES - 1)) begin
					scan_on_q <= 1'b0;
				end
			end
			if (act_s1 && idx_s1 == RI_W'(MAX_FREE_RANGES - 1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		vld_s1 <= valid_q[ptr_q];
		if (ctl.scan_start) begin
			inv_found_q <= 1'b0;
			best_found_q <= 1'b0;
			pf_q <= 1'b0;
			nf_q <= 1'b0;
			max_q <= '0;
		end else if (act_s1) begin
			if (!vld_s1 && !inv_found_q) begin
				inv_found_q <= 1'b1;
				inv_idx_q <= idx_s1;
			end
			if (vld_s1 && ent.size >= cnt_q) begin
				if (!best_found_q || ent.size < best_size_q
					|| (ent.size == best_size_q && age_gap > best_dist_q)) begin
					best_found_q <= 1'b1;
					best_idx_q <= idx_s1;
					best_start_q <= ent.start;
					best_size_q <= ent.size;
					best_dist_q <= age_gap;
				end
			end
			if (vld_s1 && ent.start <= stale_rd_q.off) begin
				if (!pf_q || ent.start >= prev_start_q) begin
					pf_q <= 1'b1;
					prev_idx_q <= idx_s1;
					prev_start_q <= ent.start;
					prev_size_q <= ent.size;
				end
			end
			if (vld_s1 && ent.start > stale_rd_q.off) begin
				if (!nf_q || ent.start < next_start_q) begin
					nf_q <= 1'b1;
					next_idx_q <= idx_s1;
					next_start_q <= ent.start;
					next_size_q <= ent.size;
				end
			end
			if (vld_s1 && ent.size > max_q) begin
				max_q <= ent.size;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status <= status_q;
			out_alloc_offset <= aoff_q;
			out_free_slots <= free_q;
			out_largest_free <= max_q;
			out_released_count <= rel_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.cmd = cmd_q;
		sts.cnt_zero = (cnt_q == '0);
		sts.cnt_gt_free = (cnt_q > free_q);
		sts.free_bad = (SUM_W'(off_q) + SUM_W'(cnt_q) > SUM_W'(heap_q));
		sts.queue_full = (fill_q >= FILL_W'(STALE_DEPTH));
		sts.queue_empty = (fill_q == '0);
		sts.head_due = (stale_rd_q.frame <= frame_q);
		sts.scan_done = done_q;
		sts.best_found = best_found_q;
		sts.merge_fail = !m_ok;
		sts.out_free = !out_valid_q || out_ready;
	end

	`BFRA_NEVER(a_fill_range, clk, arst_n, fill_q > FILL_W'(STALE_DEPTH))
	`BFRA_NEVER(a_free_le_heap, clk, arst_n, free_q > heap_q)
	`BFRA_ASSERT(a_alloc_free, clk, arst_n, ctl.alloc_commit && !cfg_we |=> free_q == $past(free_q) - $past(cnt_q))
endmodule
